/* sv/hta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hta_pkg: shared types and constants of the handle table allocator
// Command and status codes, FSM states, port widths and the row geometry of
// the usage map.
// ----------------------------------------------------------------------------
package hta_pkg;

  // Default table geometry
  localparam int unsigned HTA_ENTRIES   = 64;
  localparam int unsigned HTA_ITEM_BITS = 32;

  // Fixed port widths
  localparam int unsigned HANDLE_W = 6;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  // Widest row of the usage map
  localparam int unsigned MAX_ROW_BITS = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_NOP     = 2'd3
  } hta_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_ALLOC = 2'd2
  } hta_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } hta_state_e;

  // Bits per usage-map row: a power of two, at most MAX_ROW_BITS
  function automatic int unsigned row_bits(input int unsigned entries);
    int unsigned r;
    r = 2 ** $clog2(entries);
    return (r < MAX_ROW_BITS) ? r : MAX_ROW_BITS;
  endfunction

  // Number of usage-map rows; the row width is a power of two, so shift
  function automatic int unsigned row_count(input int unsigned entries);
    int unsigned rb;
    rb = row_bits(entries);
    return (entries + rb - 1) >> $clog2(rb);
  endfunction

  // Width of a row address (at least one bit)
  function automatic int unsigned row_addr_w(input int unsigned entries);
    int unsigned rc;
    rc = row_count(entries);
    return (rc > 1) ? $clog2(rc) : 1;
  endfunction

endpackage
`default_nettype wire

/* sv/hta_item_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hta_item_mem: item word storage
// One synchronous RAM of ENTRIES words, one write and one read port, read
// data registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module hta_item_mem #(
  parameter int unsigned ENTRIES   = hta_pkg::HTA_ENTRIES,
  parameter int unsigned ITEM_BITS = hta_pkg::HTA_ITEM_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rd_en_i,
  input  wire logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  output logic      [ITEM_BITS-1:0]       rd_data_o,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  wire logic [ITEM_BITS-1:0]       wr_data_i
);

  logic [ITEM_BITS-1:0] mem [ENTRIES];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/hta_map_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hta_map_mem: usage map of the handle table
// The in-use bits live in a row-wide synchronous RAM. Per-row valid flags
// (cleared at reset) make a never-written row read as all free, and per-row
// full flags point at the lowest row that still holds a free slot. Slots
// beyond ENTRIES read as in use.
// ----------------------------------------------------------------------------
module hta_map_mem #(
  parameter int unsigned ENTRIES = hta_pkg::HTA_ENTRIES
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          rd_en_i,
  input  wire logic [hta_pkg::row_addr_w(ENTRIES)-1:0]       rd_row_i,
  output logic      [hta_pkg::row_bits(ENTRIES)-1:0]         rd_data_o,
  input  wire logic                                          wr_en_i,
  input  wire logic [hta_pkg::row_addr_w(ENTRIES)-1:0]       wr_row_i,
  input  wire logic [hta_pkg::row_bits(ENTRIES)-1:0]         wr_data_i,
  output logic      [hta_pkg::row_addr_w(ENTRIES)-1:0]       free_row_o,
  output logic                                               any_free_o
);

  localparam int unsigned ROW_BITS = hta_pkg::row_bits(ENTRIES);
  localparam int unsigned ROWS     = hta_pkg::row_count(ENTRIES);
  localparam int unsigned ROW_W    = hta_pkg::row_addr_w(ENTRIES);

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]     row_valid_q;
  logic [ROWS-1:0]     row_full_q;
  logic [ROW_BITS-1:0] rd_raw_q;
  logic                rd_valid_q;
  logic [ROW_W-1:0]    rd_row_q;

  // Slots of a row that lie beyond the table
  function automatic logic [ROW_BITS-1:0] pad_mask(input logic [ROW_W-1:0] r);
    logic [ROW_BITS-1:0] m;
    m = '0;
    for (int unsigned c = 0; c < ROW_BITS; c++) begin
      m[c] = ((32'(r) * ROW_BITS + c) >= ENTRIES);
    end
    return m;
  endfunction

  // Row write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
  end

  // Registered row read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_row_i];
      rd_row_q <= rd_row_i;
    end
  end

  // Row valid and full flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      row_full_q  <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_row_i];
      end
      if (wr_en_i) begin
        row_valid_q[wr_row_i] <= 1'b1;
        row_full_q[wr_row_i]  <= &(wr_data_i | pad_mask(wr_row_i));
      end
    end
  end

  // Unwritten rows read as free; padding reads as used
  assign rd_data_o = (rd_valid_q ? rd_raw_q : '0) | pad_mask(rd_row_q);

  // Lowest row with a free slot
  always_comb begin
    free_row_o = '0;
    any_free_o = 1'b0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!row_full_q[i]) begin
        free_row_o = ROW_W'(i);
        any_free_o = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/handle_table_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handle_table_allocator_unit: lowest-free handle table
// Allocate stores an item under the lowest unused handle, release returns
// the item and frees the handle, lookup returns the item.
//
//   Channel  Signals                               Direction
//   in       in_valid_i / in_ready_o, command_i,   into block
//            handle_i, item_value_i
//   out      out_valid_o / out_ready_i,            out of block
//            result_handle_o, result_item_o, status_o
//
// Each command is handled in ST_IDLE and ST_EXEC: accept plus issue of the map-row and
// item reads in ST_IDLE, then ST_EXEC on the registered read data, which forms the result
// and writes the modified row (and the item on allocate) back.
// Reset clears the row valid and full flags at once; no clearing pass.
// A result waits in the output register; the next command is taken in the
// cycle that result leaves. One command is in flight at a time.
// ----------------------------------------------------------------------------
module handle_table_allocator_unit #(
  parameter int unsigned ENTRIES   = hta_pkg::HTA_ENTRIES,
  parameter int unsigned ITEM_BITS = hta_pkg::HTA_ITEM_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [hta_pkg::CMD_W-1:0]     command_i,
  input  wire logic [hta_pkg::HANDLE_W-1:0]  handle_i,
  input  wire logic [hta_pkg::ITEM_W-1:0]    item_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [hta_pkg::HANDLE_W-1:0]  result_handle_o,
  output logic      [hta_pkg::ITEM_W-1:0]    result_item_o,
  output logic      [hta_pkg::STATUS_W-1:0]  status_o
);

  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned ROW_BITS = hta_pkg::row_bits(ENTRIES);
  localparam int unsigned COL_W    = $clog2(ROW_BITS);
  localparam int unsigned ROW_W    = hta_pkg::row_addr_w(ENTRIES);

  hta_pkg::hta_state_e state_q, state_d;

  // Command registers
  hta_pkg::hta_cmd_e           cmd_q;
  logic [hta_pkg::HANDLE_W-1:0] handle_q;
  logic [IDX_W-1:0]            hidx_q;
  logic                        in_range_q;
  logic [ITEM_BITS-1:0]        item_q;
  logic [ROW_W-1:0]            alloc_row_q;
  logic                        any_free_q;

  // Output registers
  logic                         out_valid_q, out_valid_d;
  logic [hta_pkg::HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [hta_pkg::ITEM_W-1:0]   res_item_q, res_item_d;
  hta_pkg::hta_status_e         res_stat_q, res_stat_d;

  // Memory hookup
  logic                 in_fire;
  logic                 in_range;
  logic [IDX_W-1:0]     in_idx;
  logic                 map_rd_en;
  logic [ROW_W-1:0]     map_rd_row;
  logic [ROW_BITS-1:0]  map_rd_data;
  logic                 map_wr_en;
  logic [ROW_W-1:0]     map_wr_row;
  logic [ROW_BITS-1:0]  map_wr_data;
  logic [ROW_W-1:0]     free_row;
  logic                 any_free;
  logic                 item_rd_en;
  logic [ITEM_BITS-1:0] item_rd_data;
  logic                 item_wr_en;
  logic [IDX_W-1:0]     item_wr_addr;

  // Execute-stage decode
  logic [COL_W-1:0]     free_col;
  logic [COL_W-1:0]     h_col;
  logic [ROW_BITS-1:0]  free_bit;
  logic [ROW_BITS-1:0]  h_bit;
  logic                 h_used;
  logic [IDX_W-1:0]     alloc_idx;

  assign in_ready_o = (state_q == hta_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = (32'(handle_i) < ENTRIES);
  assign in_idx     = IDX_W'(handle_i);

  // Issue reads on accept
  assign map_rd_en  = in_fire;
  assign map_rd_row = (command_i == hta_pkg::CMD_ALLOC) ? free_row
                                                        : ROW_W'(in_idx >> COL_W);
  assign item_rd_en = in_fire && in_range &&
                      ((command_i == hta_pkg::CMD_RELEASE) ||
                       (command_i == hta_pkg::CMD_LOOKUP));

  hta_map_mem #(
    .ENTRIES (ENTRIES)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (map_rd_en),
    .rd_row_i   (map_rd_row),
    .rd_data_o  (map_rd_data),
    .wr_en_i    (map_wr_en),
    .wr_row_i   (map_wr_row),
    .wr_data_i  (map_wr_data),
    .free_row_o (free_row),
    .any_free_o (any_free)
  );

  hta_item_mem #(
    .ENTRIES   (ENTRIES),
    .ITEM_BITS (ITEM_BITS)
  ) u_items (
    .clk_i     (clk_i),
    .rd_en_i   (item_rd_en),
    .rd_addr_i (in_idx),
    .rd_data_o (item_rd_data),
    .wr_en_i   (item_wr_en),
    .wr_addr_i (item_wr_addr),
    .wr_data_i (item_q)
  );

  // Find the lowest free slot of the fetched row
  always_comb begin
    free_col = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!map_rd_data[i]) begin
        free_col = COL_W'(i);
      end
    end
  end

  assign h_col     = hidx_q[COL_W-1:0];
  assign free_bit  = ROW_BITS'(1) << free_col;
  assign h_bit     = ROW_BITS'(1) << h_col;
  assign h_used    = in_range_q && map_rd_data[h_col];
  assign alloc_idx = IDX_W'({alloc_row_q, free_col});

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hta_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = hta_pkg::ST_EXEC;
        end
      end
      hta_pkg::ST_EXEC: begin
        state_d = hta_pkg::ST_IDLE;
      end
      default: begin
        state_d = hta_pkg::ST_IDLE;
      end
    endcase
  end

  // Execute: form the result and write back
  always_comb begin
    map_wr_en    = 1'b0;
    map_wr_row   = alloc_row_q;
    map_wr_data  = map_rd_data;
    item_wr_en   = 1'b0;
    item_wr_addr = alloc_idx;
    res_handle_d = res_handle_q;
    res_item_d   = res_item_q;
    res_stat_d   = res_stat_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      hta_pkg::ST_EXEC: begin
        out_valid_d  = 1'b1;
        res_handle_d = handle_q;
        res_item_d   = '0;
        res_stat_d   = hta_pkg::STAT_OK;
        case (cmd_q)
          hta_pkg::CMD_ALLOC: begin
            if (any_free_q) begin
              map_wr_en    = 1'b1;
              map_wr_data  = map_rd_data | free_bit;
              item_wr_en   = 1'b1;
              res_handle_d = hta_pkg::HANDLE_W'(alloc_idx);
            end else begin
              res_handle_d = '0;
              res_stat_d   = hta_pkg::STAT_FULL;
            end
          end
          hta_pkg::CMD_RELEASE, hta_pkg::CMD_LOOKUP: begin
            if (h_used) begin
              res_item_d = hta_pkg::ITEM_W'(item_rd_data);
              if (cmd_q == hta_pkg::CMD_RELEASE) begin
                map_wr_en   = 1'b1;
                map_wr_row  = ROW_W'(hidx_q >> COL_W);
                map_wr_data = map_rd_data & ~h_bit;
              end
            end else begin
              res_stat_d = hta_pkg::STAT_NOT_ALLOC;
            end
          end
          default: begin
            res_stat_d = hta_pkg::STAT_OK;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hta_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the command transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q       <= hta_pkg::hta_cmd_e'(command_i);
      handle_q    <= handle_i;
      hidx_q      <= in_idx;
      in_range_q  <= in_range;
      item_q      <= ITEM_BITS'(item_value_i);
      alloc_row_q <= free_row;
      any_free_q  <= any_free;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    res_handle_q <= res_handle_d;
    res_item_q   <= res_item_d;
    res_stat_q   <= res_stat_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_handle_o = res_handle_q;
  assign result_item_o   = res_item_q;
  assign status_o        = res_stat_q;

endmodule
`default_nettype wire
